// File: design/lrc_pkg.sv
// ----------------------------------------------------------------------------
// LRU register cache package
// Result action codes, operation codes and entry flag types.
// ----------------------------------------------------------------------------
`default_nettype none

package lrc_pkg;

    typedef logic [1:0] op_t;
    typedef logic [2:0] action_t;

    localparam op_t OP_ACCESS  = 2'd0;
    localparam op_t OP_RELEASE = 2'd1;
    localparam op_t OP_FLUSH   = 2'd2;

    localparam action_t ACT_GRANT       = 3'd0;
    localparam action_t ACT_LOAD        = 3'd1;
    localparam action_t ACT_SEXT        = 3'd2;
    localparam action_t ACT_STORE       = 3'd3;
    localparam action_t ACT_NONE_FREE   = 3'd4;
    localparam action_t ACT_BAD_RELEASE = 3'd5;
    localparam action_t ACT_DONE        = 3'd6;

    localparam logic [1:0] SIZE_FOUR = 2'd2;

    typedef struct packed {
        logic loaded;
        logic written;
        logic rd;
    } flags_t;

endpackage

`default_nettype wire

// File: design/lru_register_cache_with_locks_top.sv
// ----------------------------------------------------------------------------
// LRU register cache with locks
// Fully associative write-back cache of memory offsets onto host registers.
// ----------------------------------------------------------------------------
//  channel   signals                                               direction
//  command   start, busy, operation, key, want_read, want_write,   in
//            size_code
//  result    strobe, action, host_register, result_key,            out
//            result_size, was_hit, size_mismatch, last
//
//  An unknown operation is dropped at acceptance. A shared scan counter
//  steps one entry per cycle for the key and for the LRU victim, a flush
//  walks the recency list one entry per cycle, storing each written and
//  loaded entry, and at most one result leaves per cycle.
//  busy drops as the result marked last is strobed. Reset clears valid bits,
//  flags, lock counts and the fill count. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_register_cache_with_locks_top #(
    parameter int POOL_REGS = 8,
    parameter int LOCK_BITS = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire lrc_pkg::op_t      operation,
    input  wire logic signed [31:0] key,
    input  wire logic              want_read,
    input  wire logic              want_write,
    input  wire logic [1:0]        size_code,
    output logic                   strobe,
    output lrc_pkg::action_t       action,
    output logic [2:0]             host_register,
    output logic signed [31:0]     result_key,
    output logic [1:0]             result_size,
    output logic                   was_hit,
    output logic                   size_mismatch,
    output logic                   last
);
    import lrc_pkg::*;

    localparam int IW = (POOL_REGS > 1) ? $clog2(POOL_REGS) : 1;
    localparam int CW = $clog2(POOL_REGS + 1);
    localparam logic [LOCK_BITS-1:0] LOCK_MAX = {LOCK_BITS{1'b1}};
    localparam logic [CW-1:0] POOL_C = CW'(POOL_REGS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIND  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_VICT  = 4'd3;
    localparam logic [3:0] S_EVICT = 4'd4;
    localparam logic [3:0] S_RW    = 4'd5;
    localparam logic [3:0] S_RW2   = 4'd6;
    localparam logic [3:0] S_ORDER = 4'd7;
    localparam logic [3:0] S_GRANT = 4'd8;
    localparam logic [3:0] S_FLUSH = 4'd9;
    localparam logic [3:0] S_FDONE = 4'd10;
    localparam logic [3:0] S_OUT1  = 4'd11;

    logic                 valid_reg [POOL_REGS];
    logic [31:0]          ekey_reg  [POOL_REGS];
    logic [1:0]           esize_reg [POOL_REGS];
    flags_t               flags_reg [POOL_REGS];
    logic [LOCK_BITS-1:0] lock_reg  [POOL_REGS];
    logic [IW-1:0]        order_reg [POOL_REGS];
    logic [CW-1:0]        used_reg;

    logic [3:0]    state_reg;
    op_t           op_reg;
    logic [31:0]   key_reg;
    logic          rd_reg, wr_reg;
    logic [1:0]    size_reg;
    logic [CW-1:0] scan_reg;
    logic          found_reg;
    logic [IW-1:0] idx_reg;
    logic [CW-1:0] pos_reg;
    logic          hit_reg;
    logic          rmv_reg;
    action_t       oact_reg;
    logic [2:0]    oreg_reg;
    logic [31:0]   okey_reg;
    logic [1:0]    osize_reg;
    logic          ohit_reg, omis_reg, olast_reg, ostb_reg;

    logic [IW-1:0] sidx;
    logic [IW-1:0] oidx;
    flags_t        fl;
    logic          scan_end;

    assign sidx     = scan_reg[IW-1:0];
    assign oidx     = order_reg[sidx];
    assign fl       = flags_reg[idx_reg];
    assign scan_end = (scan_reg == POOL_C);

    assign busy          = (state_reg != S_IDLE);
    assign strobe        = ostb_reg;
    assign action        = oact_reg;
    assign host_register = oreg_reg;
    assign result_key    = okey_reg;
    assign result_size   = osize_reg;
    assign was_hit       = ohit_reg;
    assign size_mismatch = omis_reg;
    assign last          = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            ostb_reg  <= 1'b0;
            for (int i = 0; i < POOL_REGS; i++)
            begin
                valid_reg[i] <= 1'b0;
                flags_reg[i] <= '0;
                lock_reg[i]  <= '0;
            end
        end
        else
        begin
            ostb_reg  <= 1'b0;
            olast_reg <= 1'b0;
            ohit_reg  <= 1'b0;
            omis_reg  <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= operation;
                        key_reg   <= key;
                        rd_reg    <= want_read;
                        wr_reg    <= want_write;
                        size_reg  <= size_code;
                        scan_reg  <= '0;
                        found_reg <= 1'b0;
                        unique case (operation)
                            OP_ACCESS, OP_RELEASE: state_reg <= S_FIND;
                            OP_FLUSH:              state_reg <= S_FLUSH;
                            default:               state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_FIND:
                begin
                    // compare one entry per cycle
                    if (scan_end)
                    begin
                        scan_reg <= '0;
                        if (op_reg == OP_RELEASE)
                            state_reg <= S_DEC;
                        else if (found_reg)
                        begin
                            hit_reg   <= 1'b1;
                            state_reg <= S_RW;
                        end
                        else
                        begin
                            hit_reg <= 1'b0;
                            if (used_reg < POOL_C)
                            begin
                                idx_reg   <= IW'(used_reg);
                                rmv_reg   <= 1'b0;
                                state_reg <= S_EVICT;
                            end
                            else
                                state_reg <= S_VICT;
                        end
                    end
                    else
                    begin
                        if (!found_reg && valid_reg[sidx] && ekey_reg[sidx] == key_reg)
                        begin
                            found_reg <= 1'b1;
                            idx_reg   <= sidx;
                        end
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                S_DEC:
                begin
                    ostb_reg  <= 1'b1;
                    olast_reg <= 1'b1;
                    state_reg <= S_IDLE;
                    if (!found_reg || lock_reg[idx_reg] == '0)
                    begin
                        oact_reg  <= ACT_BAD_RELEASE;
                        oreg_reg  <= found_reg ? 3'(idx_reg) : 3'd0;
                        okey_reg  <= key_reg;
                        osize_reg <= size_reg;
                    end
                    else
                    begin
                        lock_reg[idx_reg] <= lock_reg[idx_reg] - 1'b1;
                        oact_reg  <= ACT_DONE;
                        oreg_reg  <= 3'(idx_reg);
                        okey_reg  <= ekey_reg[idx_reg];
                        osize_reg <= esize_reg[idx_reg];
                    end
                end
                S_VICT:
                begin
                    // walk recency list from LRU for an unlocked entry
                    if (scan_end)
                    begin
                        ostb_reg  <= 1'b1;
                        olast_reg <= 1'b1;
                        oact_reg  <= ACT_NONE_FREE;
                        oreg_reg  <= 3'd0;
                        okey_reg  <= key_reg;
                        osize_reg <= size_reg;
                        state_reg <= S_IDLE;
                    end
                    else if (lock_reg[oidx] == '0)
                    begin
                        idx_reg   <= oidx;
                        pos_reg   <= scan_reg;
                        rmv_reg   <= 1'b1;
                        state_reg <= S_EVICT;
                    end
                    else
                        scan_reg <= scan_reg + 1'b1;
                end
                S_EVICT:
                begin
                    if (rmv_reg && fl.written && fl.loaded)
                    begin
                        ostb_reg  <= 1'b1;
                        oact_reg  <= ACT_STORE;
                        oreg_reg  <= 3'(idx_reg);
                        okey_reg  <= ekey_reg[idx_reg];
                        osize_reg <= esize_reg[idx_reg];
                    end
                    valid_reg[idx_reg] <= 1'b1;
                    ekey_reg[idx_reg]  <= key_reg;
                    esize_reg[idx_reg] <= size_reg;
                    flags_reg[idx_reg] <= '0;
                    lock_reg[idx_reg]  <= '0;
                    state_reg <= S_RW;
                end
                S_RW:
                begin
                    // read phase
                    if (rd_reg && !fl.rd)
                    begin
                        if (!fl.loaded)
                        begin
                            ostb_reg  <= 1'b1;
                            oact_reg  <= (esize_reg[idx_reg] == SIZE_FOUR) ? ACT_SEXT
                                                                           : ACT_LOAD;
                            oreg_reg  <= 3'(idx_reg);
                            okey_reg  <= ekey_reg[idx_reg];
                            osize_reg <= esize_reg[idx_reg];
                        end
                        flags_reg[idx_reg] <= '{loaded: 1'b1, written: fl.written, rd: 1'b1};
                    end
                    state_reg <= S_RW2;
                end
                S_RW2:
                begin
                    // write phase
                    if (wr_reg && !fl.written)
                    begin
                        if (fl.rd && !fl.loaded)
                        begin
                            ostb_reg  <= 1'b1;
                            oact_reg  <= (esize_reg[idx_reg] == SIZE_FOUR) ? ACT_SEXT
                                                                           : ACT_LOAD;
                            oreg_reg  <= 3'(idx_reg);
                            okey_reg  <= ekey_reg[idx_reg];
                            osize_reg <= esize_reg[idx_reg];
                        end
                        flags_reg[idx_reg] <= '{loaded: 1'b1, written: 1'b1, rd: fl.rd};
                    end
                    if (hit_reg)
                    begin
                        scan_reg  <= '0;
                        rmv_reg   <= 1'b0;
                        state_reg <= S_ORDER;
                    end
                    else
                    begin
                        pos_reg   <= rmv_reg ? pos_reg : used_reg;
                        state_reg <= S_ORDER;
                        scan_reg  <= POOL_C;
                    end
                end
                S_ORDER:
                begin
                    // locate hit entry in recency list one slot per cycle
                    if (hit_reg && !rmv_reg)
                    begin
                        if (scan_reg >= used_reg)
                        begin
                            pos_reg <= scan_reg;
                            rmv_reg <= 1'b1;
                        end
                        else if (oidx == idx_reg)
                        begin
                            pos_reg <= scan_reg;
                            rmv_reg <= 1'b1;
                        end
                        else
                            scan_reg <= scan_reg + 1'b1;
                    end
                    else
                        state_reg <= S_GRANT;
                end
                S_GRANT:
                begin
                    // shift out removed slot and append at MRU end
                    for (int i = 0; i < POOL_REGS; i++)
                    begin
                        if (CW'(i) >= pos_reg && CW'(i) + 1'b1 < used_reg)
                            order_reg[i] <= order_reg[(i + 1) % POOL_REGS];
                    end
                    if (rmv_reg && pos_reg < used_reg)
                        order_reg[IW'(used_reg - 1'b1)] <= idx_reg;
                    else
                    begin
                        order_reg[IW'(used_reg)] <= idx_reg;
                        used_reg <= used_reg + 1'b1;
                    end
                    if (hit_reg)
                    begin
                        if (lock_reg[idx_reg] != LOCK_MAX)
                            lock_reg[idx_reg] <= lock_reg[idx_reg] + 1'b1;
                    end
                    else
                        lock_reg[idx_reg] <= LOCK_BITS'(1);
                    ostb_reg  <= 1'b1;
                    olast_reg <= 1'b1;
                    oact_reg  <= ACT_GRANT;
                    oreg_reg  <= 3'(idx_reg);
                    okey_reg  <= ekey_reg[idx_reg];
                    osize_reg <= esize_reg[idx_reg];
                    ohit_reg  <= hit_reg;
                    omis_reg  <= hit_reg && (esize_reg[idx_reg] != size_reg);
                    state_reg <= S_IDLE;
                end
                S_FLUSH:
                begin
                    if (scan_reg >= used_reg)
                        state_reg <= S_FDONE;
                    else
                    begin
                        if (flags_reg[oidx].written && flags_reg[oidx].loaded)
                        begin
                            ostb_reg  <= 1'b1;
                            oact_reg  <= ACT_STORE;
                            oreg_reg  <= 3'(oidx);
                            okey_reg  <= ekey_reg[oidx];
                            osize_reg <= esize_reg[oidx];
                        end
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                S_FDONE:
                begin
                    for (int i = 0; i < POOL_REGS; i++)
                    begin
                        valid_reg[i] <= 1'b0;
                        flags_reg[i] <= '0;
                        lock_reg[i]  <= '0;
                    end
                    used_reg  <= '0;
                    ostb_reg  <= 1'b1;
                    olast_reg <= 1'b1;
                    oact_reg  <= ACT_DONE;
                    oreg_reg  <= 3'd0;
                    okey_reg  <= '0;
                    osize_reg <= 2'd0;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
